/* src/iold_pkg.sv */
// Shared types and constants for the I/O line debounce and pulse counter block.
// No dependencies; imported by every module of the block.
`default_nettype none

package iold_pkg;

    // Number of lines built; fields are always sized for MAX_LINES.
    localparam int LINES     = 4;
    localparam int MAX_LINES = 4;
    localparam int LINE_W    = (LINES > 1) ? $clog2(LINES) : 1;

    localparam int DELAY_W = 16;
    localparam int DEB_W   = DELAY_W + 1;
    localparam int PULSE_W = 21;
    localparam int COUNT_W = 32;
    localparam int CFG_W   = 64;

    localparam logic [CFG_W-1:0] DEFAULT_DELAYS = 64'h01F4_01F4_01F4_01F4;

    // Request codes
    typedef enum logic [1:0] {
        MODE_TICK  = 2'd0,
        MODE_START = 2'd1,
        MODE_CLEAR = 2'd2,
        MODE_READ  = 2'd3
    } mode_t;

    // Register indexes
    typedef enum logic [1:0] {
        REG_OUT_MASK   = 2'd0,
        REG_LOGIC_MASK = 2'd1,
        REG_LEVEL_MASK = 2'd2,
        REG_DELAYS     = 2'd3
    } reg_idx_t;

    typedef struct packed {
        logic [1:0]           mode;
        logic [1:0]           line_index;
        logic [MAX_LINES-1:0] raw_inputs;
        logic [MAX_LINES-1:0] logic_levels;
        logic [PULSE_W-1:0]   pulse_ticks;
    } in_word_t;

    typedef struct packed {
        logic [MAX_LINES-1:0] filtered_levels;
        logic [MAX_LINES-1:0] changed_lines;
        logic [MAX_LINES-1:0] drive_levels;
        logic [COUNT_W-1:0]   line_pulse_count;
        logic                 line_pulse_active;
    } out_word_t;

    // State of one line
    typedef struct packed {
        logic               last_raw;
        logic               level;
        logic [DEB_W-1:0]   deb_left;
        logic [PULSE_W-1:0] pulse_left;
        logic [COUNT_W-1:0] rise;
    } line_state_t;

    // Per-line controls and samples for the shared update unit
    typedef struct packed {
        logic               is_out;
        logic               use_logic;
        logic               steady;
        logic               logic_bit;
        logic               raw_bit;
        logic [DELAY_W-1:0] delay;
    } line_ctl_t;

endpackage

`default_nettype wire

/* src/io_line_debounce_pulse_counter.sv */
// Top level of the I/O line debounce and pulse counter: sequencer, line state, registers.
// Depends on iold_pkg and iold_line_unit.
//
// Usage:
//   Input channel (in_valid/in_ready/in_data) takes one request word: a one-millisecond
//   tick, a pulse start, a pulse counter clear, or a line read. Every word returns exactly
//   one result word on the output channel (out_valid/out_ready/out_data).
//   Configuration channel (cfg_valid/cfg_ready/cfg_index/cfg_data) writes the three line
//   masks and the packed debounce delays; it is always ready and should be used while idle.
// Timing:
//   A tick walks the lines through one shared update unit, one line per cycle, and then
//   registers its result in the final state. Other requests go straight to the final
//   state and register their result there. in_ready is low from acceptance until the
//   block is back in idle.
//   The result sits in an output register; a new word is accepted while it waits, and the
//   block stalls in its final cycle only if the previous result has not yet been taken.
// Reset:
//   rst_n clears all line state, pulse counters and masks, and sets every debounce delay
//   to 500 ms. No clearing pass is needed; the block is ready right after reset.
`default_nettype none

module io_line_debounce_pulse_counter (
    input  wire logic                     clk,
    input  wire logic                     rst_n,
    input  wire logic                     in_valid,
    output logic                          in_ready,
    input  wire iold_pkg::in_word_t       in_data,
    output logic                          out_valid,
    input  wire logic                     out_ready,
    output iold_pkg::out_word_t           out_data,
    input  wire logic                     cfg_valid,
    output logic                          cfg_ready,
    input  wire iold_pkg::reg_idx_t       cfg_index,
    input  wire logic [iold_pkg::CFG_W-1:0] cfg_data
);
    import iold_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_TICK = 3'b010,
        S_FIN  = 3'b100
    } state_t;

    state_t state_reg, state_next;

    logic [LINE_W-1:0]    line_cnt_reg, line_cnt_next;
    logic [MAX_LINES-1:0] changed_reg, changed_next;
    in_word_t             req_reg;

    // configuration registers
    logic [MAX_LINES-1:0] out_mask_reg;
    logic [MAX_LINES-1:0] logic_mask_reg;
    logic [MAX_LINES-1:0] level_mask_reg;
    logic [CFG_W-1:0]     delays_reg;

    // line state
    logic                 last_raw_reg [LINES];
    logic [LINES-1:0]     level_reg;
    logic [DEB_W-1:0]     deb_reg      [LINES];
    logic [PULSE_W-1:0]   pulse_reg    [LINES];
    logic [COUNT_W-1:0]   rise_reg     [LINES];

    out_word_t            out_reg, out_next;
    logic                 out_valid_reg;

    logic [LINE_W-1:0]    addr;
    logic                 idx_ok;
    logic                 in_fire;
    logic                 fin_go;
    logic                 last_line;
    line_state_t          cur;
    line_state_t          nxt;
    line_ctl_t            ctl;
    logic                 line_changed;
    logic [MAX_LINES-1:0] levels;

    assign in_ready  = (state_reg == S_IDLE);
    assign in_fire   = in_valid && in_ready;
    assign cfg_ready = 1'b1;
    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

    assign fin_go    = (state_reg == S_FIN) && (!out_valid_reg || out_ready);
    assign last_line = (line_cnt_reg == LINE_W'(LINES - 1));
    assign idx_ok    = ({1'b0, req_reg.line_index} < 3'(LINES));

    // one read/write port into the line state
    assign addr = (state_reg == S_TICK) ? line_cnt_reg : req_reg.line_index[LINE_W-1:0];

    always_comb
    begin
        cur.last_raw   = last_raw_reg[addr];
        cur.level      = level_reg[addr];
        cur.deb_left   = deb_reg[addr];
        cur.pulse_left = pulse_reg[addr];
        cur.rise       = rise_reg[addr];
        ctl.is_out     = out_mask_reg[addr];
        ctl.use_logic  = logic_mask_reg[addr];
        ctl.steady     = level_mask_reg[addr];
        ctl.logic_bit  = req_reg.logic_levels[addr];
        ctl.raw_bit    = req_reg.raw_inputs[addr];
        ctl.delay      = delays_reg[DELAY_W*addr +: DELAY_W];
    end

    iold_line_unit u_line_unit (
        .cur     (cur),
        .ctl     (ctl),
        .nxt     (nxt),
        .changed (line_changed)
    );

    // sequencer
    always_comb
    begin
        state_next    = state_reg;
        line_cnt_next = line_cnt_reg;
        changed_next  = changed_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_fire)
                begin
                    line_cnt_next = '0;
                    changed_next  = '0;
                    state_next    = (in_data.mode == MODE_TICK) ? S_TICK : S_FIN;
                end
            end
            S_TICK:
            begin
                changed_next[addr] = line_changed;
                line_cnt_next      = line_cnt_reg + LINE_W'(1);
                if (last_line)
                begin
                    state_next = S_FIN;
                end
            end
            S_FIN:
            begin
                if (fin_go)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            line_cnt_reg <= '0;
            changed_reg  <= '0;
        end
        else
        begin
            state_reg    <= state_next;
            line_cnt_reg <= line_cnt_next;
            changed_reg  <= changed_next;
        end
    end

    // request word holding register
    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            req_reg <= in_data;
        end
    end

    // configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_mask_reg   <= '0;
            logic_mask_reg <= '0;
            level_mask_reg <= '0;
            delays_reg     <= DEFAULT_DELAYS;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                REG_OUT_MASK:   out_mask_reg   <= cfg_data[MAX_LINES-1:0];
                REG_LOGIC_MASK: logic_mask_reg <= cfg_data[MAX_LINES-1:0];
                REG_LEVEL_MASK: level_mask_reg <= cfg_data[MAX_LINES-1:0];
                REG_DELAYS:     delays_reg     <= cfg_data;
                default:        ;
            endcase
        end
    end

    // line state: tick updates one line per cycle, pulse/clear act in the final cycle
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            level_reg <= '0;
            for (int i = 0; i < LINES; i++)
            begin
                last_raw_reg[i] <= 1'b0;
                deb_reg[i]      <= '0;
                pulse_reg[i]    <= '0;
                rise_reg[i]     <= '0;
            end
        end
        else if (state_reg == S_TICK)
        begin
            last_raw_reg[addr] <= nxt.last_raw;
            level_reg[addr]    <= nxt.level;
            deb_reg[addr]      <= nxt.deb_left;
            pulse_reg[addr]    <= nxt.pulse_left;
            rise_reg[addr]     <= nxt.rise;
        end
        else if (fin_go && idx_ok)
        begin
            if (req_reg.mode == MODE_START)
            begin
                pulse_reg[addr] <= req_reg.pulse_ticks;
            end
            else if (req_reg.mode == MODE_CLEAR)
            begin
                rise_reg[addr] <= '0;
            end
        end
    end

    // result word, reflecting the request's update to the line state
    always_comb
    begin
        levels = '0;
        for (int i = 0; i < LINES; i++)
        begin
            levels[i] = level_reg[i];
        end
        out_next.filtered_levels   = levels;
        out_next.changed_lines     = (req_reg.mode == MODE_TICK) ? changed_reg : '0;
        out_next.drive_levels      = levels & out_mask_reg;
        out_next.line_pulse_count  = '0;
        out_next.line_pulse_active = 1'b0;
        if (idx_ok)
        begin
            out_next.line_pulse_count  = (req_reg.mode == MODE_CLEAR) ? '0 : cur.rise;
            out_next.line_pulse_active = (req_reg.mode == MODE_START)
                                         ? (req_reg.pulse_ticks != '0)
                                         : (cur.pulse_left != '0);
        end
    end

    always_ff @(posedge clk)
    begin
        if (fin_go)
        begin
            out_reg <= out_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (fin_go)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    // an accepted word leaves the block busy in the following cycle
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        in_fire |=> !in_ready)
        else $error("block ready right after accepting a word");

    // the line walk never steps past the last line
    a_line_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_TICK) |-> ({1'b0, line_cnt_reg} < (LINE_W + 1)'(LINES)))
        else $error("line counter out of range");

    // only ticks report changed lines
    a_changed_tick_only: assert property (@(posedge clk) disable iff (!rst_n)
        (fin_go && req_reg.mode != MODE_TICK) |-> (out_next.changed_lines == '0))
        else $error("changed lines reported outside a tick");

    // drive levels are a subset of the line levels
    a_drive_subset: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> ((out_reg.drive_levels & ~out_reg.filtered_levels) == '0))
        else $error("drive level set on a low line");

endmodule

`default_nettype wire

/* src/iold_line_unit.sv */
// Shared per-line tick update: pulse countdown, output drive, debounce, edge count.
// Depends on iold_pkg.
`default_nettype none

module iold_line_unit (
    input  wire iold_pkg::line_state_t cur,
    input  wire iold_pkg::line_ctl_t   ctl,
    output iold_pkg::line_state_t      nxt,
    output logic                       changed
);
    import iold_pkg::*;

    logic pulsing;
    logic drv;

    always_comb
    begin
        nxt     = cur;
        changed = 1'b0;
        pulsing = (cur.pulse_left != '0);
        drv     = 1'b0;

        // pulse countdown runs on every line
        if (pulsing)
        begin
            nxt.pulse_left = cur.pulse_left - PULSE_W'(1);
        end

        if (ctl.is_out)
        begin
            // output line: steady or logic level, inverted during a pulse
            drv = (ctl.use_logic ? ctl.logic_bit : ctl.steady) ^ pulsing;
            if (cur.level != drv)
            begin
                nxt.level = drv;
                changed   = 1'b1;
            end
        end
        else
        begin
            // input line: restart the countdown on a raw change
            if (ctl.raw_bit != cur.last_raw)
            begin
                nxt.last_raw = ctl.raw_bit;
                nxt.deb_left = {1'b0, ctl.delay} + DEB_W'(1);
            end
            else if (cur.deb_left != '0)
            begin
                nxt.deb_left = cur.deb_left - DEB_W'(1);
            end

            // settled: take the raw level, count rising edges
            if (nxt.deb_left == '0 && cur.level != nxt.last_raw)
            begin
                nxt.level = nxt.last_raw;
                changed   = 1'b1;
                if (nxt.last_raw)
                begin
                    nxt.rise = cur.rise + COUNT_W'(1);
                end
            end
        end
    end

endmodule

`default_nettype wire

/* test/io_line_debounce_pulse_counter_tb.sv */
`timescale 1ns / 1ps
// Self-checking testbench for io_line_debounce_pulse_counter: a queue-fed driver and a
// result monitor with an inline line predictor. Depends on iold_pkg and the block's RTL.

module io_line_debounce_pulse_counter_tb;

    import iold_pkg::*;

    localparam int    HOLD_CYCLES    = 200;
    localparam int    SPEC_PULSE_MAX = 1800000;
    localparam int    MAX_REPORTS    = 40;
    localparam longint TIMEOUT_NS    = 40_000_000;

    logic clk = 1'b0;
    logic rst_n;

    logic      in_valid;
    logic      in_ready;
    in_word_t  in_data;
    logic      out_valid;
    logic      out_ready;
    out_word_t out_data;
    logic      cfg_valid;
    logic      cfg_ready;
    reg_idx_t  cfg_index;
    logic [CFG_W-1:0] cfg_data;

    // Request words waiting for the driver, results waiting for the monitor
    in_word_t  req_fifo[$];
    out_word_t due_results[$];

    // Predicted register contents
    logic [MAX_LINES-1:0] m_out_mask;
    logic [MAX_LINES-1:0] m_logic_mask;
    logic [MAX_LINES-1:0] m_level_mask;
    logic [CFG_W-1:0]     m_delays;

    // Predicted line state
    logic [MAX_LINES-1:0] m_last_raw;
    logic [MAX_LINES-1:0] m_level;
    logic [DEB_W-1:0]     m_deb_left   [MAX_LINES];
    logic [PULSE_W-1:0]   m_pulse_left [MAX_LINES];
    logic [COUNT_W-1:0]   m_rise       [MAX_LINES];

    int unsigned mismatches;
    logic        in_taken;
    int unsigned tx_gap;
    int unsigned rx_stall_left;
    bit          tx_gaps_on;
    bit          rx_stalls_on;
    bit          hold_req;
    bit          hold_done;
    logic [MAX_LINES-1:0] pin_levels;

    io_line_debounce_pulse_counter i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #6 clk = ~clk;

    // Idle length: often none, as often short, now and then long
    function automatic int unsigned gap_len();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 45)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic void line_state_reset();
        int i;
        m_out_mask   = '0;
        m_logic_mask = '0;
        m_level_mask = '0;
        m_delays     = DEFAULT_DELAYS;
        m_last_raw   = '0;
        m_level      = '0;
        for (i = 0; i < MAX_LINES; i++)
        begin
            m_deb_left[i]   = '0;
            m_pulse_left[i] = '0;
            m_rise[i]       = '0;
        end
    endfunction

    // Applies one request word to the predicted state and returns its result word
    function automatic out_word_t line_model_step(input in_word_t req);
        logic [MAX_LINES-1:0] changed;
        logic                 pulsing;
        logic                 drv;
        int                   i;
        int                   idx;
        bit                   in_range;
        out_word_t            res;
        changed  = '0;
        idx      = req.line_index;
        in_range = idx < LINES;
        case (mode_t'(req.mode))
            MODE_TICK:
            begin
                for (i = 0; i < LINES; i++)
                begin
                    pulsing = m_pulse_left[i] != '0;
                    if (pulsing)
                        m_pulse_left[i] = m_pulse_left[i] - 1'b1;
                    if (m_out_mask[i])
                    begin
                        // output line: steady or logic level, inverted while pulsing
                        drv = m_logic_mask[i] ? req.logic_levels[i] : m_level_mask[i];
                        drv = drv ^ pulsing;
                        if (m_level[i] != drv)
                        begin
                            m_level[i] = drv;
                            changed[i] = 1'b1;
                        end
                    end
                    else
                    begin
                        // input line: restart countdown on raw change, settle at zero
                        if (req.raw_inputs[i] != m_last_raw[i])
                        begin
                            m_last_raw[i] = req.raw_inputs[i];
                            m_deb_left[i] = {1'b0, m_delays[DELAY_W*i +: DELAY_W]} + 1'b1;
                        end
                        else if (m_deb_left[i] != '0)
                            m_deb_left[i] = m_deb_left[i] - 1'b1;
                        if (m_deb_left[i] == '0 && m_level[i] != m_last_raw[i])
                        begin
                            m_level[i] = m_last_raw[i];
                            changed[i] = 1'b1;
                            if (m_level[i])
                                m_rise[i] = m_rise[i] + 1'b1;
                        end
                    end
                end
            end
            MODE_START:
            begin
                if (in_range)
                    m_pulse_left[idx] = req.pulse_ticks;
            end
            MODE_CLEAR:
            begin
                if (in_range)
                    m_rise[idx] = '0;
            end
            default:
            begin
            end
        endcase
        res.filtered_levels   = m_level;
        res.changed_lines     = changed;
        res.drive_levels      = m_level & m_out_mask;
        res.line_pulse_count  = in_range ? m_rise[idx] : '0;
        res.line_pulse_active = in_range && m_pulse_left[idx] != '0;
        return res;
    endfunction

    task automatic note_mismatch(input string what, input logic [COUNT_W-1:0] want,
                                 input logic [COUNT_W-1:0] got);
        mismatches++;
        if (mismatches <= MAX_REPORTS)
            $display("%0t ns: %s mismatch, expected %0h, actual %0h", $time, what, want, got);
    endtask

    // Driver: presents queued words, idles between them when gaps are enabled
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (in_valid && !in_taken)
            begin
                // word still waiting for acceptance
            end
            else if (tx_gap != 0)
            begin
                in_valid <= 1'b0;
                tx_gap   <= tx_gap - 1;
            end
            else if (req_fifo.size() != 0)
            begin
                in_data  <= req_fifo.pop_front();
                in_valid <= 1'b1;
                tx_gap   <= tx_gaps_on ? gap_len() : 0;
            end
            else
                in_valid <= 1'b0;
        end
    end

    // Receiver: random stalls, plus one long hold-off on request
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (rx_stall_left != 0)
            begin
                out_ready     <= 1'b0;
                rx_stall_left <= rx_stall_left - 1;
            end
            else if (hold_req && !hold_done)
            begin
                out_ready     <= 1'b0;
                rx_stall_left <= HOLD_CYCLES - 1;
                hold_done     <= 1'b1;
            end
            else if (!rx_stalls_on || $urandom_range(0, 99) < 65)
                out_ready <= 1'b1;
            else
            begin
                out_ready     <= 1'b0;
                rx_stall_left <= gap_len();
            end
        end
    end

    // Monitor: checks taken results, predicts each accepted request
    always @(posedge clk)
    begin : scoreboard
        out_word_t want;
        if (!rst_n)
            in_taken <= 1'b0;
        else
        begin
            in_taken <= in_valid && in_ready;
            if (out_valid && out_ready)
            begin
                if (due_results.size() == 0)
                begin
                    mismatches++;
                    $display("%0t ns: unexpected result word, expected none, actual %0h",
                             $time, out_data);
                end
                else
                begin
                    want = due_results.pop_front();
                    if (out_data.filtered_levels !== want.filtered_levels)
                        note_mismatch("filtered_levels", COUNT_W'(want.filtered_levels),
                                      COUNT_W'(out_data.filtered_levels));
                    if (out_data.changed_lines !== want.changed_lines)
                        note_mismatch("changed_lines", COUNT_W'(want.changed_lines),
                                      COUNT_W'(out_data.changed_lines));
                    if (out_data.drive_levels !== want.drive_levels)
                        note_mismatch("drive_levels", COUNT_W'(want.drive_levels),
                                      COUNT_W'(out_data.drive_levels));
                    if (out_data.line_pulse_count !== want.line_pulse_count)
                        note_mismatch("line_pulse_count", want.line_pulse_count,
                                      out_data.line_pulse_count);
                    if (out_data.line_pulse_active !== want.line_pulse_active)
                        note_mismatch("line_pulse_active", COUNT_W'(want.line_pulse_active),
                                      COUNT_W'(out_data.line_pulse_active));
                end
            end
            if (in_valid && in_ready)
                due_results.push_back(line_model_step(in_data));
        end
    end

    task automatic push_req(input mode_t mode, input int idx, input logic [MAX_LINES-1:0] raw,
                            input logic [MAX_LINES-1:0] lvl, input logic [PULSE_W-1:0] ticks);
        in_word_t w;
        w.mode         = mode;
        w.line_index   = idx[1:0];
        w.raw_inputs   = raw;
        w.logic_levels = lvl;
        w.pulse_ticks  = ticks;
        req_fifo.push_back(w);
    endtask

    // Random traffic: pins mostly steady with occasional toggles, a few glitch words
    task automatic queue_traffic(input int unsigned count, input int unsigned flip_pct);
        int unsigned n;
        int unsigned r;
        mode_t       mode;
        logic [MAX_LINES-1:0] raw;
        logic [PULSE_W-1:0]   ticks;
        for (n = 0; n < count; n++)
        begin
            r = $urandom_range(0, 99);
            if (r < 60)
                mode = MODE_TICK;
            else if (r < 75)
                mode = MODE_START;
            else if (r < 83)
                mode = MODE_CLEAR;
            else
                mode = MODE_READ;
            if ($urandom_range(0, 99) < flip_pct)
                pin_levels[$urandom_range(0, MAX_LINES - 1)] ^= 1'b1;
            raw = ($urandom_range(0, 99) < 5) ? MAX_LINES'($urandom) : pin_levels;
            r = $urandom_range(0, 99);
            if (r < 10)
                ticks = '0;
            else if (r < 14)
                ticks = PULSE_W'($urandom_range(1000, (1 << PULSE_W) - 1));
            else
                ticks = PULSE_W'($urandom_range(1, 12));
            push_req(mode, $urandom_range(0, 3), raw, MAX_LINES'($urandom), ticks);
        end
    endtask

    // Registers are touched only here, with the block idle
    task automatic write_reg(input reg_idx_t idx, input logic [CFG_W-1:0] val);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do
            @(posedge clk);
        while (!cfg_ready);
        case (idx)
            REG_OUT_MASK:   m_out_mask   = val[MAX_LINES-1:0];
            REG_LOGIC_MASK: m_logic_mask = val[MAX_LINES-1:0];
            REG_LEVEL_MASK: m_level_mask = val[MAX_LINES-1:0];
            REG_DELAYS:     m_delays     = val;
            default:        ;
        endcase
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    task automatic write_masks(input logic [MAX_LINES-1:0] outs, input logic [MAX_LINES-1:0] srcs,
                               input logic [MAX_LINES-1:0] lvls, input logic [CFG_W-1:0] dly);
        write_reg(REG_OUT_MASK, CFG_W'(outs));
        write_reg(REG_LOGIC_MASK, CFG_W'(srcs));
        write_reg(REG_LEVEL_MASK, CFG_W'(lvls));
        write_reg(REG_DELAYS, dly);
    endtask

    // Wait until every queued word is through and every result is taken
    task automatic drain();
        while (req_fifo.size() != 0 || in_valid || due_results.size() != 0)
            @(posedge clk);
        repeat (10) @(posedge clk);
    endtask

    function automatic logic [CFG_W-1:0] short_delays(input int unsigned top);
        return {DELAY_W'($urandom_range(0, top)), DELAY_W'($urandom_range(0, top)),
                DELAY_W'($urandom_range(0, top)), DELAY_W'($urandom_range(0, top))};
    endfunction

    initial
    begin : stimulus
        int i;
        rst_n         = 1'b0;
        in_valid      = 1'b0;
        in_data       = '0;
        out_ready     = 1'b0;
        cfg_valid     = 1'b0;
        cfg_index     = REG_OUT_MASK;
        cfg_data      = '0;
        mismatches    = 0;
        tx_gap        = 0;
        rx_stall_left = 0;
        tx_gaps_on    = 1'b1;
        rx_stalls_on  = 1'b1;
        hold_req      = 1'b0;
        hold_done     = 1'b0;
        pin_levels    = '0;
        line_state_reset();
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Directed: reset state, pulse length extremes, stop, reload on glitch
        for (i = 0; i < MAX_LINES; i++)
            push_req(MODE_READ, i, '0, '0, '0);
        push_req(MODE_START, 0, '0, '0, {PULSE_W{1'b1}});
        push_req(MODE_START, 1, '0, '0, PULSE_W'(SPEC_PULSE_MAX));
        push_req(MODE_START, 2, '0, '0, PULSE_W'(1));
        push_req(MODE_READ, 0, '0, '0, '0);
        push_req(MODE_START, 0, '1, '1, '0);
        push_req(MODE_READ, 0, '0, '0, {PULSE_W{1'b1}});
        push_req(MODE_TICK, 1, '1, '1, '0);
        push_req(MODE_TICK, 2, '0, '0, '0);
        push_req(MODE_TICK, 3, '1, '0, '0);
        push_req(MODE_READ, 2, '0, '0, '0);
        push_req(MODE_CLEAR, 3, '0, '0, '0);
        push_req(MODE_READ, 1, '0, '0, '0);
        // hold all pins high past the default 500 ms delay so every line rises once
        for (i = 0; i < 505; i++)
            push_req(MODE_TICK, i % MAX_LINES, '1, MAX_LINES'(i), '0);
        for (i = 0; i < MAX_LINES; i++)
            push_req(MODE_READ, i, '1, '0, '0);
        push_req(MODE_CLEAR, 2, '1, '0, '0);
        push_req(MODE_READ, 2, '1, '0, '0);
        pin_levels = '1;
        drain();

        // Zero delay, mixed directions, logic source bit set on an input line
        write_masks(4'b0011, 4'b0101, 4'b1010, '0);
        queue_traffic(60, 30);
        drain();

        // All outputs, no idling on either side
        tx_gaps_on   = 1'b0;
        rx_stalls_on = 1'b0;
        write_masks(4'b1111, 4'b0011, 4'b1100, short_delays(3));
        push_req(MODE_READ, 0, '0, '0, '0);
        queue_traffic(50, 30);
        drain();

        // All inputs, longest delay on line 0
        tx_gaps_on   = 1'b1;
        rx_stalls_on = 1'b1;
        write_masks(4'b0000, 4'b1111, 4'b0000, {16'd2, 16'd0, 16'd1, 16'hFFFF});
        push_req(MODE_READ, 3, '0, '0, '0);
        queue_traffic(60, 25);
        drain();

        // Long receiver hold-off while the sender keeps offering words
        tx_gaps_on = 1'b0;
        write_masks(4'b0101, MAX_LINES'($urandom), MAX_LINES'($urandom), short_delays(4));
        hold_req = 1'b1;
        queue_traffic(70, 30);
        drain();

        // Fully random settings
        tx_gaps_on = 1'b1;
        for (i = 0; i < 2; i++)
        begin
            write_masks(MAX_LINES'($urandom), MAX_LINES'($urandom), MAX_LINES'($urandom),
                        short_delays(5));
            queue_traffic(30, 35);
            drain();
        end

        repeat (20) @(posedge clk);
        if (mismatches == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

    initial
    begin : watchdog
        #(TIMEOUT_NS);
        $display("[FAIL] regression broken");
        $finish;
    end

endmodule
